>>> hdl/point_rotate_translate_project_top_assert.svh
// ----------------------------------------------------------------------------
// Point rotate/project assertion macros
// Shared concurrent check macros for the point projection pipeline.
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_TRANSLATE_PROJECT_TOP_ASSERT_SVH
`define POINT_ROTATE_TRANSLATE_PROJECT_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point pipeline check failed");

// next-cycle implication, sampled on clk, off during reset
`define PRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point pipeline check failed");

`endif

>>> hdl/prt_pkg.sv
// ----------------------------------------------------------------------------
// Point rotate/project package
// Widths, constants and shared types for the point projection pipeline.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TRIG_BITS = 18;
  localparam int TSH       = TRIG_BITS - 2;

  localparam int IN_W   = 32;
  localparam int CFG_W  = 32;
  localparam int ANG_W  = 16;
  localparam int LENS_W = 31;
  localparam int SCR_W  = 16;

  // each rotation stage may grow a coordinate by one bit
  localparam int CW   = IN_W + 3;
  localparam int XW   = CW + 1;                 // after camera subtract
  localparam int DW   = CW + 2;                 // depth
  localparam int PX_W = XW + LENS_W + 1;        // lens * coordinate
  localparam int PD_W = DW + FRAC_BITS + 8;     // scaled depth * screen offset
  localparam int NW   = (PX_W > PD_W ? PX_W : PD_W) + 1;
  localparam int DMW  = DW + FRAC_BITS;         // scaled depth
  localparam int QB   = SCR_W;                  // quotient bits, top one is overflow
  localparam int CMPW = (NW > DMW + QB - 1) ? NW : DMW + QB - 1;

  localparam longint DEPTH_OFS = longint'(256) <<< FRAC_BITS;
  localparam int     SCR_X_OFS = 160;
  localparam int     SCR_Y_OFS = 100;

  localparam logic signed [CFG_W-1:0]  CAM_Z_RST = 32'sd16777216;
  localparam logic        [LENS_W-1:0] LENS_RST  = 31'd16777216;

  localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
  localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

  // sine polynomial coefficients, Q30
  localparam logic [30:0] QC1 = 31'd1686629713;
  localparam logic [30:0] QC3 = 31'd693598668;
  localparam logic [30:0] QC5 = 31'd85569306;
  localparam logic [30:0] QC7 = 31'd5026995;
  localparam logic [30:0] QC9 = 31'd172272;

  localparam logic signed [TRIG_BITS-1:0] TONE = TRIG_BITS'(1) <<< TSH;

  typedef enum logic [2:0] {
    REG_CAM_X   = 3'd0,
    REG_CAM_Y   = 3'd1,
    REG_CAM_Z   = 3'd2,
    REG_ANGLE_X = 3'd3,
    REG_ANGLE_Y = 3'd4,
    REG_ANGLE_Z = 3'd5,
    REG_LENS    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_MUL,
    TRIG_ACC
  } trig_state_t;

  typedef struct packed {
    logic signed [TRIG_BITS-1:0] cos_x;
    logic signed [TRIG_BITS-1:0] sin_x;
    logic signed [TRIG_BITS-1:0] cos_y;
    logic signed [TRIG_BITS-1:0] sin_y;
    logic signed [TRIG_BITS-1:0] cos_z;
    logic signed [TRIG_BITS-1:0] sin_z;
  } trig_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] cam_x;
    logic signed [CFG_W-1:0] cam_y;
    logic signed [CFG_W-1:0] cam_z;
    logic        [LENS_W-1:0] lens;
  } cam_t;

  // rotated pair p,q and the untouched coordinate r
  typedef struct packed {
    logic signed [CW-1:0] p;
    logic signed [CW-1:0] q;
    logic signed [CW-1:0] r;
  } rot_t;

  // divider lane pair sharing one divisor
  typedef struct packed {
    logic [CMPW-1:0] nx;
    logic [CMPW-1:0] ny;
    logic [CMPW-1:0] dc;
    logic [QB-1:0]   qx;
    logic [QB-1:0]   qy;
    logic            negx;
    logic            negy;
    logic            zero;
  } div_t;

endpackage

>>> hdl/prt_trig.sv
// ----------------------------------------------------------------------------
// Trig table sequencer
// Rebuilds the six sine/cosine words with one shared multiplier.
// ----------------------------------------------------------------------------
module prt_trig (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [prt_pkg::ANG_W-1:0] angle_x,
  input  logic [prt_pkg::ANG_W-1:0] angle_y,
  input  logic [prt_pkg::ANG_W-1:0] angle_z,
  output logic                      busy,
  output prt_pkg::trig_t            trig
);
  import prt_pkg::*;

  localparam logic [2:0] STEP_SQ   = 3'd0;
  localparam logic [2:0] STEP_C9   = 3'd1;
  localparam logic [2:0] STEP_C5   = 3'd2;
  localparam logic [2:0] STEP_C3   = 3'd3;
  localparam logic [2:0] STEP_LAST = 3'd5;
  localparam logic [2:0] IDX_LAST  = 3'd5;

  trig_state_t state_r, state_nxt;
  logic [2:0]  idx_r, step_r;
  logic [29:0] x2_r;
  logic [30:0] t_r;
  logic [60:0] prod_r;
  logic signed [TRIG_BITS-1:0] trig_r [6];

  logic              mul_en, acc_en;
  logic [ANG_W-1:0]  ang, ph;
  logic [14:0]       k;
  logic [29:0]       xq;
  logic [29:0]       mul_a;
  logic [30:0]       mul_b;
  logic [30:0]       shr;
  logic [30:0]       coef;
  logic [31:0]       yr;
  logic [TRIG_BITS-1:0] ys, v;
  logic signed [TRIG_BITS-1:0] res;

  // phase of the entry in work: even entries are cosines
  always_comb begin
    case (idx_r[2:1])
      2'd0:    ang = angle_x;
      2'd1:    ang = angle_y;
      default: ang = angle_z;
    endcase
    ph = idx_r[0] ? ang : ang + ANG_W'(16384);
    k  = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    xq = {k[13:0], 16'b0};
  end

  // shared multiplier operands
  always_comb begin
    mul_a = (step_r == STEP_SQ || step_r == STEP_LAST) ? xq : x2_r;
    case (step_r)
      STEP_SQ: mul_b = {1'b0, xq};
      STEP_C9: mul_b = QC9;
      default: mul_b = t_r;
    endcase
    shr = prod_r[60:30];
    case (step_r)
      STEP_C9: coef = QC7;
      STEP_C5: coef = QC5;
      STEP_C3: coef = QC3;
      default: coef = QC1;
    endcase
  end

  // final round, cap at one and quadrant sign
  always_comb begin
    yr  = {1'b0, shr} + (32'd1 << (31 - TRIG_BITS));
    ys  = yr[31 -: TRIG_BITS];
    v   = (k[14] || ys > TRIG_BITS'(TONE)) ? TRIG_BITS'(TONE) : ys;
    res = ph[15] ? -$signed(v) : $signed(v);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TRIG_IDLE: state_nxt = TRIG_IDLE;
      TRIG_MUL:  state_nxt = TRIG_ACC;
      TRIG_ACC: begin
        if (step_r == STEP_LAST && idx_r == IDX_LAST) state_nxt = TRIG_IDLE;
        else state_nxt = TRIG_MUL;
      end
      default:   state_nxt = TRIG_IDLE;
    endcase
    if (start) state_nxt = TRIG_MUL;
  end

  // state outputs
  always_comb begin
    busy   = (state_r != TRIG_IDLE);
    mul_en = (state_r == TRIG_MUL);
    acc_en = (state_r == TRIG_ACC);
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRIG_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        idx_r  <= '0;
        step_r <= '0;
      end else if (acc_en) begin
        if (step_r == STEP_LAST) begin
          step_r <= '0;
          idx_r  <= idx_r + 3'd1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  // polynomial datapath
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= 61'(mul_a) * 61'(mul_b);
    if (acc_en && step_r == STEP_SQ) x2_r <= prod_r[59:30];
    if (acc_en && step_r != STEP_SQ && step_r != STEP_LAST) t_r <= coef - shr;
  end

  // trig words: cosines one, sines zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) trig_r[i] <= (i % 2 == 0) ? TONE : '0;
    end else if (acc_en && !start && step_r == STEP_LAST) begin
      trig_r[idx_r] <= res;
    end
  end

  assign trig.cos_x = trig_r[0];
  assign trig.sin_x = trig_r[1];
  assign trig.cos_y = trig_r[2];
  assign trig.sin_y = trig_r[3];
  assign trig.cos_z = trig_r[4];
  assign trig.sin_z = trig_r[5];

endmodule

>>> hdl/prt_rot.sv
// ----------------------------------------------------------------------------
// Rotation cell
// Rotates one coordinate pair by a cos/sin pair, rounds, registers the beat.
// ----------------------------------------------------------------------------
module prt_rot (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  prt_pkg::rot_t                        in_data,
  input  logic signed [prt_pkg::TRIG_BITS-1:0] c,
  input  logic signed [prt_pkg::TRIG_BITS-1:0] s,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output prt_pkg::rot_t                        out_data
);
  import prt_pkg::*;

  localparam int PW = CW + TRIG_BITS;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (TSH - 1);

  logic               v_r;
  rot_t               d_r;
  logic signed [CW-1:0] pa, qa;
  logic signed [PW-1:0] pc, qs, qc, ps;
  logic signed [PW:0]   sp, sq;

  // p' = p*c - q*s, q' = q*c + p*s, both rounded half up
  always_comb begin
    pa = in_data.p;
    qa = in_data.q;
    pc = pa * c;
    qs = qa * s;
    qc = qa * c;
    ps = pa * s;
    sp = {pc[PW-1], pc} - {qs[PW-1], qs} + HALF;
    sq = {qc[PW-1], qc} + {ps[PW-1], ps} + HALF;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r.p <= sp[TSH +: CW];
      d_r.q <= sq[TSH +: CW];
      d_r.r <= in_data.r;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

>>> hdl/prt_proj.sv
// ----------------------------------------------------------------------------
// Projection front end
// Camera offset and depth, lens products, then magnitudes for the divider.
// ----------------------------------------------------------------------------
module prt_proj (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prt_pkg::rot_t  in_data,
  input  prt_pkg::cam_t  cam,
  output logic           out_valid,
  input  logic           out_ready,
  output prt_pkg::div_t  out_data
);
  import prt_pkg::*;

  logic                  a_v_r, b_v_r, c_v_r;
  logic                  rdy_a, rdy_b, rdy_c;
  logic signed [XW-1:0]  a_x_r, a_y_r;
  logic signed [DW-1:0]  a_dep_r;
  logic signed [NW-1:0]  b_nx_r, b_ny_r;
  logic signed [DMW-1:0] b_den_r;
  logic                  b_zero_r;
  div_t                  c_r;

  logic signed [XW-1:0]   xs, ys, zs;
  logic signed [DW-1:0]   czb, dep;
  logic signed [DMW-1:0]  den;
  logic signed [PX_W-1:0] plx, ply;
  logic signed [NW-1:0]   nx, ny;
  logic [NW-1:0]          mx, my;
  logic [DMW-1:0]         md;

  assign rdy_c    = !c_v_r || out_ready;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign in_ready = rdy_a;

  // camera offset and depth
  always_comb begin
    xs  = XW'(in_data.p) - XW'(cam.cam_x);
    ys  = XW'(in_data.q) - XW'(cam.cam_y);
    zs  = XW'(in_data.r) - XW'(cam.cam_z);
    czb = DW'(cam.cam_z) - DW'(DEPTH_OFS);
    dep = czb - DW'(zs);
  end

  // lens products and screen offsets folded into the numerators
  always_comb begin
    den = {a_dep_r, {FRAC_BITS{1'b0}}};
    plx = $signed({1'b0, cam.lens}) * a_x_r;
    ply = $signed({1'b0, cam.lens}) * a_y_r;
    nx  = NW'(plx) + NW'(den) * NW'(SCR_X_OFS);
    ny  = NW'(den) * NW'(SCR_Y_OFS) - NW'(ply);
  end

  // magnitudes and result signs
  always_comb begin
    mx = b_nx_r[NW-1] ? NW'(-b_nx_r) : NW'(b_nx_r);
    my = b_ny_r[NW-1] ? NW'(-b_ny_r) : NW'(b_ny_r);
    md = b_den_r[DMW-1] ? DMW'(-b_den_r) : DMW'(b_den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_x_r   <= xs;
      a_y_r   <= ys;
      a_dep_r <= dep;
    end
    if (rdy_b) begin
      b_nx_r   <= nx;
      b_ny_r   <= ny;
      b_den_r  <= den;
      b_zero_r <= (a_dep_r == '0);
    end
    if (rdy_c) begin
      c_r.nx   <= CMPW'(mx);
      c_r.ny   <= CMPW'(my);
      c_r.dc   <= CMPW'(md) << (QB - 1);
      c_r.qx   <= '0;
      c_r.qy   <= '0;
      c_r.negx <= b_nx_r[NW-1] ^ b_den_r[DMW-1];
      c_r.negy <= b_ny_r[NW-1] ^ b_den_r[DMW-1];
      c_r.zero <= b_zero_r;
    end
  end

  assign out_valid = c_v_r;
  assign out_data  = c_r;

endmodule

>>> hdl/prt_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step for both screen lanes; hands the halved divisor on.
// ----------------------------------------------------------------------------
module prt_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  prt_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prt_pkg::div_t out_data
);
  import prt_pkg::*;

  logic v_r;
  div_t d_r;
  logic gex, gey;

  // compare against the current divisor weight
  assign gex = (in_data.nx >= in_data.dc);
  assign gey = (in_data.ny >= in_data.dc);

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r.nx   <= gex ? in_data.nx - in_data.dc : in_data.nx;
      d_r.ny   <= gey ? in_data.ny - in_data.dc : in_data.ny;
      d_r.dc   <= in_data.dc >> 1;
      d_r.qx   <= {in_data.qx[QB-2:0], gex};
      d_r.qy   <= {in_data.qy[QB-2:0], gey};
      d_r.negx <= in_data.negx;
      d_r.negy <= in_data.negy;
      d_r.zero <= in_data.zero;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

>>> hdl/point_rotate_translate_project_top.sv
// Pipeline registers: 3 rotation, 3 projection, 16 divider cells, 1 output register;
//   one point per cycle sustained while out_ready is high and the trig sequencer is idle.
// After an angle write the trig sequencer rebuilds 6 words x 6 steps on one multiplier
//   with in_ready low.
// Reset (rst_n low, synchronous): pipeline empty, registers at their defaults,
//   cosines one and sines zero.
// ----------------------------------------------------------------------------
// Point rotate and project top
// Euler rotation, camera offset and perspective divide of Q16.16 points.
// ----------------------------------------------------------------------------
`include "point_rotate_translate_project_top_assert.svh"

module point_rotate_translate_project_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [prt_pkg::IN_W-1:0]    in_point_x,
  input  logic signed [prt_pkg::IN_W-1:0]    in_point_y,
  input  logic signed [prt_pkg::IN_W-1:0]    in_point_z,
  input  logic                               in_is_point,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [prt_pkg::SCR_W-1:0]   out_screen_x,
  output logic signed [prt_pkg::SCR_W-1:0]   out_screen_y,
  output logic                               out_zero_depth,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [prt_pkg::CFG_W-1:0]          cfg_wdata
);
  import prt_pkg::*;

  logic signed [CFG_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [ANG_W-1:0]        angle_x_r, angle_y_r, angle_z_r;
  logic [LENS_W-1:0]       lens_r;
  logic                    trig_start, trig_busy;
  trig_t                   trig;
  cam_t                    cam;

  logic rx_v, ry_v, rz_v, rx_rdy, ry_rdy, rz_rdy, pj_rdy;
  rot_t rx_in, rx_out, ry_in, ry_out, rz_in, rz_out;

  div_t chain_d   [QB+1];
  logic chain_v   [QB+1];
  logic chain_rdy [QB+1];

  logic                    out_valid_r, out_rdy;
  logic signed [SCR_W-1:0] sx_r, sy_r, sx, sy;
  logic                    zd_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      cam_z_r   <= CAM_Z_RST;
      angle_x_r <= '0;
      angle_y_r <= '0;
      angle_z_r <= '0;
      lens_r    <= LENS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CAM_X:   cam_x_r   <= cfg_wdata;
        REG_CAM_Y:   cam_y_r   <= cfg_wdata;
        REG_CAM_Z:   cam_z_r   <= cfg_wdata;
        REG_ANGLE_X: angle_x_r <= cfg_wdata[ANG_W-1:0];
        REG_ANGLE_Y: angle_y_r <= cfg_wdata[ANG_W-1:0];
        REG_ANGLE_Z: angle_z_r <= cfg_wdata[ANG_W-1:0];
        REG_LENS:    lens_r    <= cfg_wdata[LENS_W-1:0];
        default: ;
      endcase
    end
  end

  assign trig_start = cfg_we && (cfg_index inside {REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z});

  assign cam.cam_x = cam_x_r;
  assign cam.cam_y = cam_y_r;
  assign cam.cam_z = cam_z_r;
  assign cam.lens  = lens_r;

  prt_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (trig_start),
    .angle_x (angle_x_r),
    .angle_y (angle_y_r),
    .angle_z (angle_z_r),
    .busy    (trig_busy),
    .trig    (trig)
  );

  // input beat; non-point items are taken and dropped
  assign in_ready = rx_rdy && !trig_busy;

  // rotate about X: pair (y, z)
  assign rx_in.p = CW'(in_point_y);
  assign rx_in.q = CW'(in_point_z);
  assign rx_in.r = CW'(in_point_x);

  prt_rot u_rot_x (
    .clk (clk), .rst_n (rst_n),
    .in_valid  (in_valid && in_is_point && !trig_busy),
    .in_ready  (rx_rdy),
    .in_data   (rx_in),
    .c (trig.cos_x), .s (trig.sin_x),
    .out_valid (rx_v), .out_ready (ry_rdy), .out_data (rx_out)
  );

  // rotate about Y: pair (z, x)
  assign ry_in.p = rx_out.q;
  assign ry_in.q = rx_out.r;
  assign ry_in.r = rx_out.p;

  prt_rot u_rot_y (
    .clk (clk), .rst_n (rst_n),
    .in_valid  (rx_v), .in_ready (ry_rdy), .in_data (ry_in),
    .c (trig.cos_y), .s (trig.sin_y),
    .out_valid (ry_v), .out_ready (rz_rdy), .out_data (ry_out)
  );

  // rotate about Z: pair (x, y)
  assign rz_in.p = ry_out.q;
  assign rz_in.q = ry_out.r;
  assign rz_in.r = ry_out.p;

  prt_rot u_rot_z (
    .clk (clk), .rst_n (rst_n),
    .in_valid  (ry_v), .in_ready (rz_rdy), .in_data (rz_in),
    .c (trig.cos_z), .s (trig.sin_z),
    .out_valid (rz_v), .out_ready (pj_rdy), .out_data (rz_out)
  );

  prt_proj u_proj (
    .clk (clk), .rst_n (rst_n),
    .in_valid  (rz_v), .in_ready (pj_rdy), .in_data (rz_out),
    .cam       (cam),
    .out_valid (chain_v[0]), .out_ready (chain_rdy[0]), .out_data (chain_d[0])
  );

  // divider chain, one quotient bit per cell, overflow bit first
  for (genvar g = 0; g < QB; g++) begin : g_div
    prt_div_cell u_cell (
      .clk (clk), .rst_n (rst_n),
      .in_valid  (chain_v[g]),   .in_ready  (chain_rdy[g]),   .in_data  (chain_d[g]),
      .out_valid (chain_v[g+1]), .out_ready (chain_rdy[g+1]), .out_data (chain_d[g+1])
    );
  end

  // sign, saturation and zero depth
  always_comb begin
    if (chain_d[QB].zero) sx = '0;
    else if (chain_d[QB].qx[QB-1]) sx = chain_d[QB].negx ? SCR_MIN : SCR_MAX;
    else if (chain_d[QB].negx) sx = -$signed({1'b0, chain_d[QB].qx[QB-2:0]});
    else sx = $signed({1'b0, chain_d[QB].qx[QB-2:0]});

    if (chain_d[QB].zero) sy = '0;
    else if (chain_d[QB].qy[QB-1]) sy = chain_d[QB].negy ? SCR_MIN : SCR_MAX;
    else if (chain_d[QB].negy) sy = -$signed({1'b0, chain_d[QB].qy[QB-2:0]});
    else sy = $signed({1'b0, chain_d[QB].qy[QB-2:0]});
  end

  // output register
  assign out_rdy       = !out_valid_r || out_ready;
  assign chain_rdy[QB] = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_rdy) out_valid_r <= chain_v[QB];
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      sx_r <= sx;
      sy_r <= sy;
      zd_r <= chain_d[QB].zero;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_screen_x   = sx_r;
  assign out_screen_y   = sy_r;
  assign out_zero_depth = zd_r;

  // checks
  `PRT_ASSERT_NOW(a_trig_stall, trig_busy, !in_ready)
  `PRT_ASSERT_NOW(a_zero_clear, out_valid && out_zero_depth,
                  out_screen_x == '0 && out_screen_y == '0)
  `PRT_ASSERT_NEXT(a_angle_restart, trig_start, trig_busy)
  `PRT_ASSERT_NEXT(a_point_enters, in_valid && in_ready && in_is_point, rx_v)

endmodule
